[rtl/rcs_pkg.sv]
// ---------------------------------------------------------------------------
// rcs_pkg
// Types, constants and ranking helpers for the ranked candidate selector.
// ---------------------------------------------------------------------------
package rcs_pkg;

  localparam int MAX_CANDIDATES_DEF   = 1024;
  localparam int MAX_ALTERNATIVES_DEF = 16;

  localparam logic [30:0] NO_COMPETITOR_CONF = 31'd65536000;
  localparam logic [4:0]  TOP_K_RESET        = 5'd3;

  localparam logic CFG_MARGIN = 1'b0;
  localparam logic CFG_TOP_K  = 1'b1;

  localparam logic MODE_CAND = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ALT    = 1'b1;

  typedef struct packed {
    logic signed [30:0] score;
    logic [5:0]         prio;
    logic [3:0]         root;
    logic [3:0]         bass;
    logic [3:0]         quality;
  } cand_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_CONF,
    ST_ALT,
    ST_PREV,
    ST_EMIT
  } state_t;

  // a ranks above b; earlier arrival wins a full tie, so ties give 0
  function automatic logic ranks_above(input cand_t a, input cand_t b);
    if (a.score != b.score) return a.score > b.score;
    if (a.prio != b.prio) return a.prio < b.prio;
    if (a.root != b.root) return a.root < b.root;
    return a.bass < b.bass;
  endfunction

  function automatic logic same_symbol(input cand_t a, input logic [3:0] root,
                                       input logic [3:0] quality);
    return (a.root == root) && (a.quality == quality);
  endfunction

  function automatic logic same_voicing(input cand_t a, input logic [3:0] root,
                                        input logic [3:0] bass, input logic [3:0] quality);
    return (a.root == root) && (a.quality == quality) && (a.bass == bass);
  endfunction

endpackage

[rtl/rcs_if.sv]
// ---------------------------------------------------------------------------
// rcs_if
// Request channels of the ranked candidate selector: input, result, config.
// ---------------------------------------------------------------------------
interface rcs_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [30:0] cand_score;
  logic [5:0]         cand_priority;
  logic [3:0]         cand_root;
  logic [3:0]         cand_bass;
  logic [3:0]         cand_quality;
  logic [15:0]        slice_number;
  logic               prev_valid;
  logic [3:0]         prev_root;
  logic [3:0]         prev_bass;
  logic [3:0]         prev_quality;

  modport source (output valid, mode, cand_score, cand_priority, cand_root, cand_bass,
                  cand_quality, slice_number, prev_valid, prev_root, prev_bass,
                  prev_quality, input ready);
  modport sink (input valid, mode, cand_score, cand_priority, cand_root, cand_bass,
                cand_quality, slice_number, prev_valid, prev_root, prev_bass,
                prev_quality, output ready);
endinterface

interface rcs_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               has_chord;
  logic [15:0]        out_slice;
  logic [3:0]         out_root;
  logic [3:0]         out_bass;
  logic [3:0]         out_quality;
  logic [5:0]         out_priority;
  logic signed [30:0] out_score;
  logic [30:0]        confidence;
  logic               uncertain;
  logic               last;

  modport source (output valid, kind, has_chord, out_slice, out_root, out_bass,
                  out_quality, out_priority, out_score, confidence, uncertain, last,
                  input ready);
  modport sink (input valid, kind, has_chord, out_slice, out_root, out_bass,
                out_quality, out_priority, out_score, confidence, uncertain, last,
                output ready);
endinterface

interface rcs_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [30:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/rcs_store.sv]
// ---------------------------------------------------------------------------
// rcs_store
// Candidate memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module rcs_store import rcs_pkg::*; #(
  parameter int DEPTH = MAX_CANDIDATES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cand_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cand_t         rdata
);

  cand_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ranked_candidate_selector.sv]
// ---------------------------------------------------------------------------
// ranked_candidate_selector
// Collects scored candidates per slice and emits the winner and alternatives.
// ---------------------------------------------------------------------------
// Candidate requests are written to the store at one per cycle. An end request
// starts a series of scans over the stored candidates, limited by the single
// read port: one for the winner, one for the best different chord, one per
// alternative up to the cap (plus one that finds none when fewer alternatives
// exist), and one for the prevailing chord. An empty slice skips the scans.
// Results then leave at one per cycle while the result side is ready, the header
// first. No request is taken while a slice is being ranked or emitted.
// There is no clearing pass after reset.
module ranked_candidate_selector import rcs_pkg::*; #(
  parameter int MAX_CANDIDATES   = MAX_CANDIDATES_DEF,
  parameter int MAX_ALTERNATIVES = MAX_ALTERNATIVES_DEF
) (
  input  logic clk,
  input  logic rst,
  rcs_in_if.sink    in_ch,
  rcs_out_if.source out_ch,
  rcs_cfg_if.sink   cfg
);

  localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int NA = MAX_ALTERNATIVES + 1;
  localparam int AW = $clog2(MAX_ALTERNATIVES + 2);

  state_t state, state_next;

  logic [30:0] margin;
  logic [4:0]  top_k;
  logic [CW-1:0] count;
  logic [CW-1:0] addr;
  logic          rd_vld;
  cand_t         rd_data;

  logic [15:0] slice;
  logic        pv;
  logic [3:0]  proot, pbass, pqual;

  cand_t       win;
  logic        win_found;
  logic        have_other;
  logic signed [30:0] best_other;
  logic [30:0] conf;
  logic        unc;
  logic        has;

  cand_t       best;
  logic        best_found;
  cand_t       be, bs;
  logic        fe, fs;

  cand_t       alts [NA];
  logic [AW-1:0] alt_cnt;
  logic [AW-1:0] out_idx;
  logic [AW-1:0] cap;

  logic scanning, issue, scan_done, cand_acc, end_acc, out_acc, is_last;
  logic dup, carried;
  cand_t in_cand, out_cand;
  logic signed [31:0] diff;

  assign in_cand = '{score: in_ch.cand_score, prio: in_ch.cand_priority,
                     root: in_ch.cand_root, bass: in_ch.cand_bass,
                     quality: in_ch.cand_quality};

  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign cand_acc    = in_ch.valid && in_ch.ready && (in_ch.mode == MODE_CAND);
  assign end_acc     = in_ch.valid && in_ch.ready && (in_ch.mode == MODE_END);

  assign scanning  = (state == ST_WIN) || (state == ST_CONF) || (state == ST_ALT) ||
                     (state == ST_PREV);
  assign issue     = scanning && (addr < count);
  assign scan_done = scanning && (addr == count) && !rd_vld;

  assign cap = ((top_k == 5'd0) || (32'(top_k) > MAX_ALTERNATIVES)) ?
               AW'(MAX_ALTERNATIVES) : AW'(top_k);

  rcs_store #(.DEPTH(MAX_CANDIDATES), .AW(IW)) u_store (
    .clk   (clk),
    .we    (cand_acc && (count < CW'(MAX_CANDIDATES))),
    .waddr (count[IW-1:0]),
    .wdata (in_cand),
    .re    (issue),
    .raddr (addr[IW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    dup = 1'b0;
    carried = 1'b0;
    for (int j = 0; j < NA; j++) begin
      if (AW'(j) < alt_cnt) begin
        if (same_voicing(rd_data, alts[j].root, alts[j].bass, alts[j].quality)) dup = 1'b1;
        if (same_symbol(alts[j], proot, pqual)) carried = 1'b1;
      end
    end
  end

  assign diff = {win.score[30], win.score} - {best_other[30], best_other};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (end_acc) state_next = ST_WIN;
      ST_WIN: begin
        if (count == '0) state_next = ST_EMIT;
        else if (scan_done) state_next = ST_CONF;
      end
      ST_CONF: if (scan_done) state_next = ST_ALT;
      ST_ALT: begin
        if (scan_done && (!best_found || (alt_cnt + AW'(1) >= cap))) state_next = ST_PREV;
      end
      ST_PREV: if (scan_done) state_next = ST_EMIT;
      ST_EMIT: if (out_acc && is_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // result outputs
  always_comb begin
    out_ch.valid        = (state == ST_EMIT);
    out_cand = (out_idx == '0) ? win : alts[out_idx - AW'(1)];
    is_last  = (out_idx == alt_cnt);
    out_acc  = out_ch.valid && out_ch.ready;
    out_ch.kind         = (out_idx == '0) ? KIND_HEADER : KIND_ALT;
    out_ch.has_chord    = has;
    out_ch.out_slice    = slice;
    out_ch.out_root     = has ? out_cand.root : 4'd0;
    out_ch.out_bass     = has ? out_cand.bass : 4'd0;
    out_ch.out_quality  = has ? out_cand.quality : 4'd0;
    out_ch.out_priority = has ? out_cand.prio : 6'd0;
    out_ch.out_score    = has ? out_cand.score : 31'sd0;
    out_ch.confidence   = (out_idx == '0) ? conf : 31'd0;
    out_ch.uncertain    = (out_idx == '0) ? unc : 1'b0;
    out_ch.last         = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      margin  <= 31'd0;
      top_k   <= TOP_K_RESET;
      count   <= '0;
      addr    <= '0;
      rd_vld  <= 1'b0;
      alt_cnt <= '0;
      out_idx <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg.valid) begin
        if (cfg.index == CFG_MARGIN) margin <= cfg.data;
        else if (cfg.index == CFG_TOP_K) top_k <= cfg.data[4:0];
      end
      if (cand_acc && (count < CW'(MAX_CANDIDATES))) count <= count + CW'(1);
      if (issue) addr <= addr + CW'(1);
      else if (scan_done) addr <= '0;
      if (end_acc) begin
        alt_cnt <= '0;
        out_idx <= '0;
      end
      if ((state == ST_ALT) && scan_done && best_found) alt_cnt <= alt_cnt + AW'(1);
      if ((state == ST_PREV) && scan_done && pv && !same_symbol(win, proot, pqual) &&
          !carried && (fe || fs)) begin
        alt_cnt <= alt_cnt + AW'(1);
      end
      if (out_acc) begin
        if (is_last) begin
          count   <= '0;
          out_idx <= '0;
        end else begin
          out_idx <= out_idx + AW'(1);
        end
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (end_acc) begin
      slice      <= in_ch.slice_number;
      pv         <= in_ch.prev_valid;
      proot      <= in_ch.prev_root;
      pbass      <= in_ch.prev_bass;
      pqual      <= in_ch.prev_quality;
      win_found  <= 1'b0;
      have_other <= 1'b0;
      best_found <= 1'b0;
      fe         <= 1'b0;
      fs         <= 1'b0;
      has        <= (count != '0);
      conf       <= 31'd0;
      unc        <= 1'b1;
    end
    if (rd_vld) begin
      case (state)
        ST_WIN: begin
          if (!win_found || ranks_above(rd_data, win)) win <= rd_data;
          win_found <= 1'b1;
        end
        ST_CONF: begin
          if (!same_symbol(rd_data, win.root, win.quality)) begin
            if (!have_other || (rd_data.score > best_other)) best_other <= rd_data.score;
            have_other <= 1'b1;
          end
        end
        ST_ALT: begin
          if (!same_voicing(rd_data, win.root, win.bass, win.quality) && !dup &&
              (!best_found || ranks_above(rd_data, best))) begin
            best       <= rd_data;
            best_found <= 1'b1;
          end
        end
        ST_PREV: begin
          if (same_voicing(rd_data, proot, pbass, pqual) && (!fe || ranks_above(rd_data, be))) begin
            be <= rd_data;
            fe <= 1'b1;
          end
          if (same_symbol(rd_data, proot, pqual) && (!fs || ranks_above(rd_data, bs))) begin
            bs <= rd_data;
            fs <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if ((state == ST_CONF) && scan_done) begin
      conf <= have_other ? diff[30:0] : NO_COMPETITOR_CONF;
      unc  <= (have_other ? diff[30:0] : NO_COMPETITOR_CONF) < margin;
    end
    if ((state == ST_ALT) && scan_done) begin
      if (best_found) alts[alt_cnt] <= best;
      best_found <= 1'b0;
    end
    if ((state == ST_PREV) && scan_done) begin
      alts[alt_cnt] <= fe ? be : bs;
    end
  end

endmodule

[rtl/rcs_checker.sv]
// ---------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the ranked candidate selector, bound to the top level.
// ---------------------------------------------------------------------------
module rcs_checker import rcs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic        has_chord,
  input logic [30:0] confidence,
  input logic        uncertain,
  input logic        last,
  input logic [15:0] out_slice
);

  // no new request while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken during emit");

  // alternatives follow back to back until last
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid) else $error("gap in result burst");

  // empty slice gives a lone uncertain header
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_chord) |-> (last && uncertain && kind == KIND_HEADER))
    else $error("bad empty slice result");

  // alternatives carry no confidence
  a_alt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ALT) |-> (confidence == 31'd0 && !uncertain))
    else $error("alternative with confidence");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_slice) && $stable(kind)))
    else $error("stalled result changed");

endmodule

bind ranked_candidate_selector rcs_checker u_rcs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .has_chord  (out_ch.has_chord),
  .confidence (out_ch.confidence),
  .uncertain  (out_ch.uncertain),
  .last       (out_ch.last),
  .out_slice  (out_ch.out_slice)
);

[dv/tb_ranked_candidate_selector.sv]
// ---------------------------------------------------------------------------
// tb_ranked_candidate_selector
// Drives candidate and end-of-slice requests with bursty gaps and a stalling
// result side, predicts the header and ranked alternatives of every slice,
// and checks each result field by field in order.
// ---------------------------------------------------------------------------
module tb_ranked_candidate_selector;
  import rcs_pkg::*;

  typedef struct packed {
    logic               mode;
    logic signed [30:0] score;
    logic [5:0]         prio;
    logic [3:0]         root;
    logic [3:0]         bass;
    logic [3:0]         quality;
    logic [15:0]        slice;
    logic               pv;
    logic [3:0]         proot;
    logic [3:0]         pbass;
    logic [3:0]         pqual;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic               has_chord;
    logic [15:0]        slice;
    logic [3:0]         root;
    logic [3:0]         bass;
    logic [3:0]         quality;
    logic [5:0]         prio;
    logic signed [30:0] score;
    logic [30:0]        confidence;
    logic               uncertain;
    logic               last;
  } chord_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rcs_in_if  in_ch();
  rcs_out_if out_ch();
  rcs_cfg_if cfg();

  ranked_candidate_selector DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t       pending_reqs[$];
  chord_res_t expected_chords[$];
  cand_t      slice_cands[$];
  logic [30:0] margin_reg = '0;
  logic [4:0]  top_k_reg = TOP_K_RESET;
  int  mismatches = 0;
  int  cycles = 0;
  bit  hold_sender = 1'b0;
  bit  feeding_done = 1'b0;
  bit  cfg_busy = 1'b0;
  bit  in_accepted = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;

  function automatic void add_req(input req_t q);
    pending_reqs = {pending_reqs, q};
  endfunction

  function automatic bit outranks(int i, int j);
    cand_t a, b;
    a = slice_cands[i];
    b = slice_cands[j];
    if (a.score != b.score) return a.score > b.score;
    if (a.prio != b.prio) return a.prio < b.prio;
    if (a.root != b.root) return a.root < b.root;
    if (a.bass != b.bass) return a.bass < b.bass;
    return i < j;
  endfunction

  function automatic chord_res_t make_entry(logic kind, logic [15:0] slice, cand_t c);
    chord_res_t r;
    r = '0;
    r.kind = kind;
    r.has_chord = 1'b1;
    r.slice = slice;
    r.root = c.root;
    r.bass = c.bass;
    r.quality = c.quality;
    r.prio = c.prio;
    r.score = c.score;
    return r;
  endfunction

  task automatic rank_slice(input req_t q);
    int n, win, cap, best, be, bs;
    bit have_other, found, dup, carried;
    logic signed [31:0] best_other;
    logic [31:0] conf;
    int alts[$];
    chord_res_t hdr, entry;
    cand_t w, c, x;
    n = slice_cands.size();
    if (n == 0) begin
      hdr = '0;
      hdr.slice = q.slice;
      hdr.uncertain = 1'b1;
      hdr.last = 1'b1;
      expected_chords = {expected_chords, hdr};
      return;
    end
    win = 0;
    for (int i = 1; i < n; i++) if (outranks(i, win)) win = i;
    w = slice_cands[win];
    have_other = 0;
    best_other = 0;
    for (int i = 0; i < n; i++) begin
      c = slice_cands[i];
      if (!(c.root == w.root && c.quality == w.quality)) begin
        if (!have_other || c.score > best_other) best_other = c.score;
        have_other = 1;
      end
    end
    conf = have_other ? 32'(32'(signed'(w.score)) - best_other) : 32'(NO_COMPETITOR_CONF);
    hdr = make_entry(KIND_HEADER, q.slice, w);
    hdr.confidence = conf[30:0];
    hdr.uncertain = conf[30:0] < margin_reg;
    cap = (top_k_reg == 0 || top_k_reg > MAX_ALTERNATIVES_DEF) ? MAX_ALTERNATIVES_DEF
                                                                : int'(top_k_reg);
    while (alts.size() < cap) begin
      found = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        c = slice_cands[i];
        if (c.root == w.root && c.bass == w.bass && c.quality == w.quality) continue;
        dup = 0;
        foreach (alts[a]) begin
          x = slice_cands[alts[a]];
          if (c.root == x.root && c.bass == x.bass && c.quality == x.quality) dup = 1;
        end
        if (dup) continue;
        if (!found || outranks(i, best)) begin
          best = i;
          found = 1;
        end
      end
      if (!found) break;
      alts = {alts, best};
    end
    if (q.pv && !(w.root == q.proot && w.quality == q.pqual)) begin
      carried = 0;
      foreach (alts[a]) begin
        x = slice_cands[alts[a]];
        if (x.root == q.proot && x.quality == q.pqual) carried = 1;
      end
      if (!carried) begin
        be = -1;
        bs = -1;
        for (int i = 0; i < n; i++) begin
          c = slice_cands[i];
          if (c.root == q.proot && c.quality == q.pqual) begin
            if (c.bass == q.pbass && (be < 0 || outranks(i, be))) be = i;
            if (bs < 0 || outranks(i, bs)) bs = i;
          end
        end
        if (be >= 0) alts = {alts, be};
        else if (bs >= 0) alts = {alts, bs};
      end
    end
    hdr.last = alts.size() == 0;
    expected_chords = {expected_chords, hdr};
    foreach (alts[a]) begin
      entry = make_entry(KIND_ALT, q.slice, slice_cands[alts[a]]);
      entry.last = a == alts.size() - 1;
      expected_chords = {expected_chords, entry};
    end
  endtask

  // predictor fed on accepted requests
  always @(posedge clk) begin
    cand_t c_new;
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (in_ch.mode == MODE_CAND) begin
        if (slice_cands.size() < MAX_CANDIDATES_DEF) begin
          c_new = {in_ch.cand_score, in_ch.cand_priority, in_ch.cand_root,
                   in_ch.cand_bass, in_ch.cand_quality};
          slice_cands = {slice_cands, c_new};
        end
      end else begin
        rank_slice({in_ch.mode, in_ch.cand_score, in_ch.cand_priority, in_ch.cand_root,
                    in_ch.cand_bass, in_ch.cand_quality, in_ch.slice_number,
                    in_ch.prev_valid, in_ch.prev_root, in_ch.prev_bass,
                    in_ch.prev_quality});
        slice_cands.delete();
      end
    end
    if (!rst && cfg.valid && cfg.ready) begin
      if (cfg.index == CFG_MARGIN) margin_reg <= cfg.data;
      else top_k_reg <= cfg.data[4:0];
    end
  end

  // request taken at the last rising edge
  always @(posedge clk) begin
    in_accepted <= !rst && in_ch.valid && in_ch.ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_accepted) begin
    end else if (pending_reqs.size() == 0 || hold_sender || cfg_busy) begin
      in_ch.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_ch.valid <= 1'b0;
    end else begin
      req_t q;
      q = pending_reqs.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.mode <= q.mode;
      in_ch.cand_score <= q.score;
      in_ch.cand_priority <= q.prio;
      in_ch.cand_root <= q.root;
      in_ch.cand_bass <= q.bass;
      in_ch.cand_quality <= q.quality;
      in_ch.slice_number <= q.slice;
      in_ch.prev_valid <= q.pv;
      in_ch.prev_root <= q.proot;
      in_ch.prev_bass <= q.pbass;
      in_ch.prev_quality <= q.pqual;
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(0, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // result side stalls in phases of its own
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) out_ch.ready <= 1'b0;
    else if (stall_phase[7:6] == 2'd0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk) begin
    chord_res_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.kind, out_ch.has_chord, out_ch.out_slice, out_ch.out_root,
             out_ch.out_bass, out_ch.out_quality, out_ch.out_priority, out_ch.out_score,
             out_ch.confidence, out_ch.uncertain, out_ch.last};
      if (expected_chords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_chords.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic req_t cand_req(logic signed [30:0] s, logic [5:0] p, logic [3:0] r,
                                    logic [3:0] b, logic [3:0] qq);
    req_t q;
    q = '0;
    q.mode = MODE_CAND;
    q.score = s;
    q.prio = p;
    q.root = r;
    q.bass = b;
    q.quality = qq;
    q.slice = 16'($urandom);
    q.pv = 1'($urandom);
    q.proot = 4'($urandom);
    q.pbass = 4'($urandom);
    q.pqual = 4'($urandom);
    return q;
  endfunction

  function automatic req_t end_req(logic [15:0] sl, logic pv, logic [3:0] r, logic [3:0] b,
                                   logic [3:0] qq);
    req_t q;
    q = '0;
    q.mode = MODE_END;
    q.score = 31'($urandom);
    q.prio = 6'($urandom);
    q.root = 4'($urandom);
    q.bass = 4'($urandom);
    q.quality = 4'($urandom);
    q.slice = sl;
    q.pv = pv;
    q.proot = r;
    q.pbass = b;
    q.pqual = qq;
    return q;
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_chords.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    drain();
    cfg_busy = 1'b1;
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  task automatic random_slices(input int budget);
    int n, kind;
    logic [3:0] r, b, qq;
    req_t q;
    while (budget > 0) begin
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
        kind = $urandom_range(0, 3);
        q = cand_req(kind == 0 ? 31'($urandom) : 31'($urandom_range(0, 6)),
                     kind == 0 ? 6'($urandom) : 6'($urandom_range(0, 2)),
                     4'($urandom_range(0, 3)), 4'($urandom_range(0, 2)),
                     4'($urandom_range(0, 2)));
        if (kind == 1) begin
          q.root = 4'($urandom_range(0, 11));
          q.bass = 4'($urandom_range(0, 11));
          q.quality = 4'($urandom);
        end
        add_req(q);
      end
      r = 4'($urandom_range(0, 3));
      b = 4'($urandom_range(0, 2));
      qq = 4'($urandom_range(0, 2));
      add_req(end_req(16'($urandom), $urandom_range(0, 3) != 0, r, b, qq));
      budget -= n + 1;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_CAND;
    in_ch.cand_score = '0;
    in_ch.cand_priority = '0;
    in_ch.cand_root = '0;
    in_ch.cand_bass = '0;
    in_ch.cand_quality = '0;
    in_ch.slice_number = '0;
    in_ch.prev_valid = 1'b0;
    in_ch.prev_root = '0;
    in_ch.prev_bass = '0;
    in_ch.prev_quality = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_MARGIN;
    cfg.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty slice, then extremes and ties
    add_req(end_req(16'hFFFF, 1'b1, 4'd3, 4'd3, 4'd3));
    add_req(cand_req(31'sh3FFFFFFF, 6'd63, 4'd11, 4'd11, 4'd15));
    add_req(cand_req(-31'sh40000000, 6'd0, 4'd0, 4'd0, 4'd0));
    add_req(cand_req(-31'sh40000000, 6'd0, 4'd0, 4'd0, 4'd0));
    add_req(end_req(16'h0000, 1'b0, 4'd0, 4'd0, 4'd0));
    // single symbol only: no competitor
    add_req(cand_req(31'sd100, 6'd5, 4'd2, 4'd2, 4'd1));
    add_req(cand_req(31'sd100, 6'd5, 4'd2, 4'd7, 4'd1));
    add_req(end_req(16'd7, 1'b1, 4'd2, 4'd9, 4'd1));
    // prevailing chord beyond cap, exact voicing preferred
    for (int i = 0; i < 6; i++)
      add_req(cand_req(31'(600 - 50 * i), 6'(i), 4'(i), 4'(i), 4'd2));
    add_req(cand_req(31'sd10, 6'd1, 4'd9, 4'd4, 4'd6));
    add_req(cand_req(31'sd20, 6'd1, 4'd9, 4'd5, 4'd6));
    add_req(end_req(16'd42, 1'b1, 4'd9, 4'd4, 4'd6));
    add_req(cand_req(31'sd5, 6'd0, 4'd1, 4'd1, 4'd1));
    add_req(cand_req(31'sd5, 6'd0, 4'd1, 4'd2, 4'd1));
    add_req(end_req(16'd43, 1'b1, 4'd1, 4'd9, 4'd1));
    drain();

    write_reg(CFG_MARGIN, 31'h7FFFFFFF);
    write_reg(CFG_TOP_K, 31'd0);
    random_slices(70);
    hold_sender = 1'b1;
    while (in_ch.valid || expected_chords.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    write_reg(CFG_TOP_K, 31'd16);
    write_reg(CFG_MARGIN, 31'd0);
    random_slices(70);
    write_reg(CFG_TOP_K, 31'd1);
    write_reg(CFG_MARGIN, 31'd3);
    random_slices(70);
    write_reg(CFG_TOP_K, 31'd31);
    write_reg(CFG_MARGIN, 31'($urandom));
    random_slices(70);
    write_reg(CFG_TOP_K, 31'd3);
    write_reg(CFG_MARGIN, 31'd2);
    random_slices(70);
    drain();
    if (mismatches == 0 && expected_chords.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
